FILE: rtl/mvt_pkg.sv
`timescale 1ns / 1ps

package mvt_pkg;

  // Default sizing of the matrix datapath.
  localparam int MVT_MAX_DIM   = 4;
  localparam int MVT_ELEM_BITS = 32;

  // Fixed widths of the transfer fields and of the configuration port.
  localparam int FIELD_BITS   = 32;
  localparam int NUM_LANES    = 4;
  localparam int ROW_IDX_BITS = 2;
  localparam int CFG_BITS     = 3;
  localparam int CFG_IDX_BITS = 1;

  // Reset values of the configuration registers.
  localparam logic [CFG_BITS-1:0] VECTOR_SIZE_RST = 3'd4;
  localparam logic [CFG_BITS-1:0] ROW_COUNT_RST   = 3'd4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_VECTOR_SIZE = 1'b0,
    CFG_ROW_COUNT   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_LOAD      = 1'b0,
    ACT_TRANSFORM = 1'b1
  } action_e;

  // One input transfer: a matrix row or a vector.
  typedef struct packed {
    logic                         action;
    logic [ROW_IDX_BITS-1:0]      row_index;
    logic signed [FIELD_BITS-1:0] elem_0;
    logic signed [FIELD_BITS-1:0] elem_1;
    logic signed [FIELD_BITS-1:0] elem_2;
    logic signed [FIELD_BITS-1:0] elem_3;
  } mvt_in_t;

  // One result transfer: the dot product of each row with the vector.
  typedef struct packed {
    logic signed [FIELD_BITS-1:0] res_0;
    logic signed [FIELD_BITS-1:0] res_1;
    logic signed [FIELD_BITS-1:0] res_2;
    logic signed [FIELD_BITS-1:0] res_3;
  } mvt_out_t;

  // Control handed from the top level to each row datapath.
  typedef struct packed {
    logic advance;
    logic row_en;
  } mvt_row_ctrl_t;

endpackage

FILE: rtl/mvt_stream_if.sv
`timescale 1ns / 1ps

interface mvt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/mvt_row_dot.sv
`timescale 1ns / 1ps

module mvt_row_dot
  import mvt_pkg::*;
#(
  parameter int MAX_DIM   = MVT_MAX_DIM,
  parameter int ELEM_BITS = MVT_ELEM_BITS
) (
  input  logic                         clk_i,
  input  mvt_row_ctrl_t                ctrl_i,
  input  logic [MAX_DIM-1:0]           col_en_i,
  input  logic signed [ELEM_BITS-1:0]  row_i [MAX_DIM],
  input  logic signed [ELEM_BITS-1:0]  vec_i [MAX_DIM],
  output logic signed [FIELD_BITS-1:0] res_o
);

  localparam int FRAC_BITS = ELEM_BITS / 2;
  localparam int PROD_BITS = 2 * ELEM_BITS;
  localparam int PAIR_BITS = PROD_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int NUM_PAIRS = (MAX_DIM + 1) / 2;

  logic signed [PROD_BITS-1:0]  prod_d [MAX_DIM];
  logic signed [PROD_BITS-1:0]  prod_q [MAX_DIM];
  logic signed [PAIR_BITS-1:0]  pair_d [NUM_PAIRS];
  logic signed [PAIR_BITS-1:0]  pair_q [NUM_PAIRS];
  logic                         row_en_a_q;
  logic                         row_en_b_q;
  logic signed [SUM_BITS-1:0]   total;
  logic signed [SUM_BITS-1:0]   shifted;
  logic signed [SUM_BITS-1:0]   hi_lim;
  logic signed [SUM_BITS-1:0]   lo_lim;
  logic signed [ELEM_BITS-1:0]  sat;
  logic signed [FIELD_BITS-1:0] res_d;
  logic signed [FIELD_BITS-1:0] res_q;

  // Stage A: one exact signed product per column; unused columns contribute zero.
  always_comb begin
    for (int c = 0; c < MAX_DIM; c++) begin
      prod_d[c] = '0;
      if (col_en_i[c]) begin
        prod_d[c] = row_i[c] * vec_i[c];
      end
    end
  end

  // Stage B: add the products in pairs.
  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
    if (2 * p + 1 < MAX_DIM) begin : g_two
      assign pair_d[p] = PAIR_BITS'(prod_q[2*p]) + PAIR_BITS'(prod_q[2*p+1]);
    end else begin : g_one
      assign pair_d[p] = PAIR_BITS'(prod_q[2*p]);
    end
  end

  // Stage C: final sum, floor shift back to the element format and saturation; disabled rows give zero.
  always_comb begin
    total = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      total = total + SUM_BITS'(pair_q[p]);
    end
    shifted = total >>> FRAC_BITS;
    hi_lim  = {{(SUM_BITS - ELEM_BITS + 1){1'b0}}, {(ELEM_BITS - 1){1'b1}}};
    lo_lim  = ~hi_lim;
    if (shifted > hi_lim) begin
      sat = hi_lim[ELEM_BITS-1:0];
    end else if (shifted < lo_lim) begin
      sat = lo_lim[ELEM_BITS-1:0];
    end else begin
      sat = shifted[ELEM_BITS-1:0];
    end
    res_d = row_en_b_q ? FIELD_BITS'(sat) : '0;
  end

  // Datapath registers, all moving together on the pipeline advance.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      prod_q     <= prod_d;
      pair_q     <= pair_d;
      res_q      <= res_d;
      row_en_a_q <= ctrl_i.row_en;
      row_en_b_q <= row_en_a_q;
    end
  end

  assign res_o = res_q;

endmodule

FILE: rtl/matrix_vector_transform.sv
`timescale 1ns / 1ps
// A transform transfer passes through the input register, product, pair sum and result
// registers in that order before its result shows on the output.
// Throughput: one item per cycle; the whole pipeline stalls only while a result waits.
// Load items update the matrix as they leave the input register and give no result.
// Reset clears the valid flags and sets vector_size and row_count to 4; matrix undefined.

module matrix_vector_transform
  import mvt_pkg::*;
#(
  parameter int MAX_DIM   = MVT_MAX_DIM,
  parameter int ELEM_BITS = MVT_ELEM_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  mvt_stream_if.sink              in_if,
  mvt_stream_if.source            out_if,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i
);

  logic                        advance;
  logic                        s1_valid_q;
  mvt_in_t                     s1_item_q;
  logic                        s2_valid_q;
  logic                        s3_valid_q;
  logic                        out_valid_q;
  logic [CFG_BITS-1:0]         vector_size_q;
  logic [CFG_BITS-1:0]         row_count_q;
  logic [CFG_BITS-1:0]         vs_clamp;
  logic [CFG_BITS-1:0]         rows_clamp;
  logic [MAX_DIM-1:0]          col_en;
  logic [NUM_LANES-1:0]        row_en;
  logic signed [FIELD_BITS-1:0] s1_elem [NUM_LANES];
  logic signed [ELEM_BITS-1:0] vec [MAX_DIM];
  logic signed [ELEM_BITS-1:0] mat_q [MAX_DIM][MAX_DIM];
  logic signed [FIELD_BITS-1:0] res [NUM_LANES];
  logic                        s1_transform;

  // The pipeline moves whenever the output register is free or being drained.
  assign advance     = !out_valid_q || out_if.ready;
  assign in_if.ready = advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_size_q <= VECTOR_SIZE_RST;
      row_count_q   <= ROW_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VECTOR_SIZE: vector_size_q <= cfg_data_i;
        CFG_ROW_COUNT:   row_count_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid flags of the pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_if.valid;
      s2_valid_q  <= s1_transform;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_item_q <= in_if.data;
    end
  end

  assign s1_transform = s1_valid_q && (s1_item_q.action == ACT_TRANSFORM);

  // Vector components taken from the low element bits.
  assign s1_elem[0] = s1_item_q.elem_0;
  assign s1_elem[1] = s1_item_q.elem_1;
  assign s1_elem[2] = s1_item_q.elem_2;
  assign s1_elem[3] = s1_item_q.elem_3;

  always_comb begin
    for (int c = 0; c < MAX_DIM; c++) begin
      vec[c] = s1_elem[c][ELEM_BITS-1:0];
    end
  end

  // Matrix store: a load writes its whole row as it leaves the input register,
  // so every transform ahead of it has already read the old contents.
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q && (s1_item_q.action == ACT_LOAD)) begin
      for (int r = 0; r < MAX_DIM; r++) begin
        if (s1_item_q.row_index == ROW_IDX_BITS'(r)) begin
          mat_q[r] <= vec;
        end
      end
    end
  end

  // Clamp the vector size to 2..MAX_DIM and the row count to the vector size.
  always_comb begin
    if (vector_size_q < CFG_BITS'(2)) begin
      vs_clamp = CFG_BITS'(2);
    end else if (vector_size_q > CFG_BITS'(MAX_DIM)) begin
      vs_clamp = CFG_BITS'(MAX_DIM);
    end else begin
      vs_clamp = vector_size_q;
    end
    rows_clamp = (row_count_q > vs_clamp) ? vs_clamp : row_count_q;
    for (int c = 0; c < MAX_DIM; c++) begin
      col_en[c] = CFG_BITS'(c) < vs_clamp;
    end
    for (int r = 0; r < NUM_LANES; r++) begin
      row_en[r] = CFG_BITS'(r) < rows_clamp;
    end
  end

  // One dot-product datapath per stored row; missing rows read zero.
  for (genvar r = 0; r < NUM_LANES; r++) begin : g_row
    if (r < MAX_DIM) begin : g_used
      mvt_row_ctrl_t ctrl;
      assign ctrl.advance = advance;
      assign ctrl.row_en  = row_en[r];

      mvt_row_dot #(
        .MAX_DIM  (MAX_DIM),
        .ELEM_BITS(ELEM_BITS)
      ) u_row (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl),
        .col_en_i(col_en),
        .row_i   (mat_q[r]),
        .vec_i   (vec),
        .res_o   (res[r])
      );
    end else begin : g_absent
      assign res[r] = '0;
    end
  end

  // Result transfer.
  assign out_if.valid      = out_valid_q;
  assign out_if.data.res_0 = res[0];
  assign out_if.data.res_1 = res[1];
  assign out_if.data.res_2 = res[2];
  assign out_if.data.res_3 = res[3];

  // A load leaving the input register never enters the product stage.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_valid_q && (s1_item_q.action == ACT_LOAD)) |=> !s2_valid_q)
    else $error("load item entered the arithmetic pipeline");

  // A result appears only after a transform reached the last sum stage.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s3_valid_q))
    else $error("result valid without a transform in flight");

  // While stalled, the inner stages keep their contents.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(s2_valid_q) && $stable(s3_valid_q) && $stable(s1_valid_q)))
    else $error("pipeline moved during a stall");

endmodule
